/* rtl/bsad_pkg.sv */
// ----------------------------------------------------------------------------
// Bank-switch address decoder package
// Shared widths, codes, latch bit positions and transfer structures.
// ----------------------------------------------------------------------------
package bsad_pkg;

	localparam int ADDR_W      = 16;
	localparam int LATCH_W     = 8;
	localparam int OFFS_W      = 14;
	localparam int ROME_SIZE_W = 14;
	localparam int ROMC_SIZE_W = 13;
	localparam int MODEL_W     = 2;
	localparam int SEL_W       = 2;
	localparam int BANK_W      = 2;
	localparam int REGION_W    = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 14;

	localparam logic FUNC_WRITE = 1'b0;

	localparam int PA_ROME_BIT   = 0;
	localparam int PA_RAM0_BIT   = 1;
	localparam int PA_VIDEO_BIT  = 2;
	localparam int PA_BASIC_BIT  = 7;
	localparam int PB_RAM8_BIT   = 5;
	localparam int BS_RAM3_BIT   = 4;
	localparam int BS_VBANK_LSB  = 1;
	localparam int RE_RAM1_BIT   = 0;
	localparam int RE_ROMC_BIT   = 7;

	localparam logic [OFFS_W-1:0] VIDEO_BANKED_END = 14'h2800;

	typedef enum logic [REGION_W-1:0] {
		REGION_NONE  = 3'd0,
		REGION_RAM   = 3'd1,
		REGION_VIDEO = 3'd2,
		REGION_BASIC = 3'd3,
		REGION_ROMC  = 3'd4,
		REGION_ROME  = 3'd5
	} region_t;

	typedef enum logic [MODEL_W-1:0] {
		MODEL_FIRST = 2'd0,
		MODEL_BASIC = 2'd1,
		MODEL_EXT   = 2'd2,
		MODEL_NONE  = 2'd3
	} model_t;

	typedef enum logic [SEL_W-1:0] {
		SEL_PORT_A     = 2'd0,
		SEL_PORT_B     = 2'd1,
		SEL_BANK_SEL   = 2'd2,
		SEL_RAM_ROM_EN = 2'd3
	} latch_sel_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MACHINE_MODEL = 2'd0,
		CFG_OS_ROM_E_SIZE = 2'd1,
		CFG_OS_ROM_C_SIZE = 2'd2
	} cfg_reg_t;

	localparam model_t                 MODEL_RESET = MODEL_EXT;
	localparam logic [ROME_SIZE_W-1:0] ROME_RESET  = 14'd8192;
	localparam logic [ROMC_SIZE_W-1:0] ROMC_RESET  = 13'd4096;

	typedef struct packed {
		logic [LATCH_W-1:0] port_a;
		logic [LATCH_W-1:0] port_b;
		logic [LATCH_W-1:0] bank_sel;
		logic [LATCH_W-1:0] ram_rom_en;
	} latches_t;

	typedef struct packed {
		model_t                 model;
		logic [ROME_SIZE_W-1:0] rom_e_size;
		logic [ROMC_SIZE_W-1:0] rom_c_size;
	} cfg_t;

	typedef struct packed {
		logic               func;
		latch_sel_t         latch_select;
		logic [LATCH_W-1:0] latch_data;
		logic [ADDR_W-1:0]  cpu_address;
	} item_t;

	typedef struct packed {
		logic              mapped;
		region_t           target_region;
		logic [BANK_W-1:0] bank_index;
		logic [OFFS_W-1:0] region_offset;
		logic              writable;
	} result_t;

endpackage

/* rtl/bsad_ctrl_regs.sv */
// ----------------------------------------------------------------------------
// Bank-switch control registers
// Configuration registers and the four bank-control latches with write logic.
// ----------------------------------------------------------------------------
module bsad_ctrl_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bsad_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bsad_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             advance,
	input  bsad_pkg::item_t                  item,
	output bsad_pkg::cfg_t                   cfg,
	output bsad_pkg::latches_t               latches_next
);

	bsad_pkg::cfg_t     cfg_q;
	bsad_pkg::latches_t latches_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.model      <= bsad_pkg::MODEL_RESET;
			cfg_q.rom_e_size <= bsad_pkg::ROME_RESET;
			cfg_q.rom_c_size <= bsad_pkg::ROMC_RESET;
		end else if (cfg_we) begin
			case (bsad_pkg::cfg_reg_t'(cfg_index))
				bsad_pkg::CFG_MACHINE_MODEL: begin
					cfg_q.model <= bsad_pkg::model_t'(cfg_data[bsad_pkg::MODEL_W-1:0]);
				end
				bsad_pkg::CFG_OS_ROM_E_SIZE: begin
					cfg_q.rom_e_size <= cfg_data[bsad_pkg::ROME_SIZE_W-1:0];
				end
				bsad_pkg::CFG_OS_ROM_C_SIZE: begin
					cfg_q.rom_c_size <= cfg_data[bsad_pkg::ROMC_SIZE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Ports 0x84 and 0x86 exist only on the third model.
	always_comb begin
		latches_next = latches_q;
		if (item.func == bsad_pkg::FUNC_WRITE) begin
			unique case (item.latch_select)
				bsad_pkg::SEL_PORT_A: begin
					latches_next.port_a = item.latch_data;
				end
				bsad_pkg::SEL_PORT_B: begin
					latches_next.port_b = item.latch_data;
				end
				bsad_pkg::SEL_BANK_SEL: begin
					if (cfg_q.model == bsad_pkg::MODEL_EXT)
						latches_next.bank_sel = item.latch_data;
				end
				bsad_pkg::SEL_RAM_ROM_EN: begin
					if (cfg_q.model == bsad_pkg::MODEL_EXT)
						latches_next.ram_rom_en = item.latch_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latches_q <= '0;
		end else if (advance) begin
			latches_q <= latches_next;
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/bsad_decode.sv */
// ----------------------------------------------------------------------------
// Bank-switch address translation
// Maps a CPU address to region, bank, offset and writable flag.
// ----------------------------------------------------------------------------
module bsad_decode (
	input  bsad_pkg::cfg_t                   cfg,
	input  bsad_pkg::latches_t               latches,
	input  logic [bsad_pkg::ADDR_W-1:0]      addr,
	output bsad_pkg::result_t                result
);

	logic [bsad_pkg::OFFS_W-1:0] offs;
	logic [bsad_pkg::OFFS_W-1:0] offs_e;
	logic                        in_low;
	logic                        in_ram1;
	logic                        in_high;
	logic                        in_basic;
	logic                        in_c;
	logic                        in_e;
	logic                        rom_e_hit;
	logic                        rom_c_hit;
	logic                        legacy;
	logic                        ext;
	bsad_pkg::region_t           region;
	logic [bsad_pkg::BANK_W-1:0] bank;

	assign offs     = addr[bsad_pkg::OFFS_W-1:0];
	assign offs_e   = {1'b0, addr[bsad_pkg::OFFS_W-2:0]};
	assign in_low   = (addr[15:14] == 2'b00);
	assign in_ram1  = (addr[15:14] == 2'b01);
	assign in_high  = (addr[15:14] == 2'b10);
	assign in_c     = (addr[15:14] == 2'b11);
	assign in_basic = (addr[15:13] == 3'b110);
	assign in_e     = (addr[15:13] == 3'b111);
	assign rom_e_hit = in_e && (offs_e < cfg.rom_e_size);
	assign rom_c_hit = in_c && (offs < {1'b0, cfg.rom_c_size});
	assign legacy = (cfg.model == bsad_pkg::MODEL_FIRST) || (cfg.model == bsad_pkg::MODEL_BASIC);
	assign ext    = (cfg.model == bsad_pkg::MODEL_EXT);

	// Later mappings override earlier ones.
	always_comb begin
		region = bsad_pkg::REGION_NONE;
		bank   = '0;
		if (legacy || ext) begin
			if (latches.port_a[bsad_pkg::PA_RAM0_BIT] && in_low) begin
				region = bsad_pkg::REGION_RAM;
			end
		end
		if (ext && latches.ram_rom_en[bsad_pkg::RE_RAM1_BIT] && in_ram1) begin
			region = bsad_pkg::REGION_RAM;
			bank   = 2'd1;
		end
		if (ext && latches.port_b[bsad_pkg::PB_RAM8_BIT] && in_high) begin
			region = bsad_pkg::REGION_RAM;
			bank   = latches.bank_sel[bsad_pkg::BS_RAM3_BIT] ? 2'd3 : 2'd2;
		end
		if ((legacy || ext) && latches.port_a[bsad_pkg::PA_VIDEO_BIT] && in_high) begin
			region = bsad_pkg::REGION_VIDEO;
			bank   = '0;
			if (ext && (offs < bsad_pkg::VIDEO_BANKED_END))
				bank = latches.bank_sel[bsad_pkg::BS_VBANK_LSB +: bsad_pkg::BANK_W];
		end
		if (((cfg.model == bsad_pkg::MODEL_BASIC) || ext) &&
			latches.port_a[bsad_pkg::PA_BASIC_BIT] && in_basic) begin
			region = bsad_pkg::REGION_BASIC;
			bank   = '0;
		end
		if (ext && latches.ram_rom_en[bsad_pkg::RE_ROMC_BIT] && rom_c_hit) begin
			region = bsad_pkg::REGION_ROMC;
			bank   = '0;
		end
		if ((legacy || ext) && latches.port_a[bsad_pkg::PA_ROME_BIT] && rom_e_hit) begin
			region = bsad_pkg::REGION_ROME;
			bank   = '0;
		end
	end

	always_comb begin
		result.target_region = region;
		result.bank_index    = bank;
		result.mapped        = (region != bsad_pkg::REGION_NONE);
		result.writable      = (region == bsad_pkg::REGION_RAM) ||
			(region == bsad_pkg::REGION_VIDEO);
		if (region == bsad_pkg::REGION_NONE)
			result.region_offset = '0;
		else if (region == bsad_pkg::REGION_ROME)
			result.region_offset = offs_e;
		else
			result.region_offset = offs;
	end

endmodule

/* rtl/bank_switch_address_decoder.sv */
// ----------------------------------------------------------------------------
// Bank-switch address decoder
// Each item is held in the input register and then in the result register before its result is valid.
// Throughput is one item per cycle while the receiver does not stall, set by the input and result registers.
// A latch write in an item takes effect for that item's own translation.
// Reset clears the latches and valid flags and loads default configuration.
// ----------------------------------------------------------------------------
module bank_switch_address_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bsad_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bsad_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic                             func,
	input  logic [bsad_pkg::SEL_W-1:0]       latch_select,
	input  logic [bsad_pkg::LATCH_W-1:0]     latch_data,
	input  logic [bsad_pkg::ADDR_W-1:0]      cpu_address,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic                             mapped,
	output logic [bsad_pkg::REGION_W-1:0]    target_region,
	output logic [bsad_pkg::BANK_W-1:0]      bank_index,
	output logic [bsad_pkg::OFFS_W-1:0]      region_offset,
	output logic                             writable
);

	logic                valid_s1;
	bsad_pkg::item_t     item_s1;
	logic                valid_s2;
	bsad_pkg::result_t   result_s2;
	logic                accept;
	logic                advance;
	bsad_pkg::cfg_t      cfg;
	bsad_pkg::latches_t  latches_next;
	bsad_pkg::result_t   result_next;

	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.func         <= func;
			item_s1.latch_select <= bsad_pkg::latch_sel_t'(latch_select);
			item_s1.latch_data   <= latch_data;
			item_s1.cpu_address  <= cpu_address;
		end
	end

	bsad_ctrl_regs u_ctrl_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.advance      (advance),
		.item         (item_s1),
		.cfg          (cfg),
		.latches_next (latches_next)
	);

	bsad_decode u_decode (
		.cfg     (cfg),
		.latches (latches_next),
		.addr    (item_s1.cpu_address),
		.result  (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	assign result_valid  = valid_s2;
	assign mapped        = result_s2.mapped;
	assign target_region = result_s2.target_region;
	assign bank_index    = result_s2.bank_index;
	assign region_offset = result_s2.region_offset;
	assign writable      = result_s2.writable;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("Input stalled with no item held in the input register.");

	a_mapped_region: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (mapped == (target_region != bsad_pkg::REGION_NONE)))
		else $error("Mapped flag disagrees with the target region.");

	a_unmapped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !mapped) |-> (bank_index == '0 && region_offset == '0 && !writable))
		else $error("Unmapped result carries nonzero fields.");

	a_rom_not_writable: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && writable) |->
			(target_region == bsad_pkg::REGION_RAM || target_region == bsad_pkg::REGION_VIDEO))
		else $error("ROM region flagged as writable.");

endmodule

/* tb/sv/bsad_translation_monitor.sv */
// ----------------------------------------------------------------------------
// Bank-switch address decoder translation monitor
// Watches the configuration port and both transfer channels, keeps its own
// copy of the control latches and configuration, predicts the translation
// of every accepted item and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module bsad_translation_monitor
	import bsad_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   item_valid,
	input  logic                   item_stall,
	input  logic                   func,
	input  logic [SEL_W-1:0]       latch_select,
	input  logic [LATCH_W-1:0]     latch_data,
	input  logic [ADDR_W-1:0]      cpu_address,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  logic                   mapped,
	input  logic [REGION_W-1:0]    target_region,
	input  logic [BANK_W-1:0]      bank_index,
	input  logic [OFFS_W-1:0]      region_offset,
	input  logic                   writable,
	output int unsigned            mismatches,
	output int unsigned            outstanding
);

	latches_t    latch_copy;
	cfg_t        cfg_copy;
	result_t     expected_translations[$];
	result_t     oldest;
	int unsigned err_count;

	function automatic result_t region_hit(region_t rg, int unsigned bank, int unsigned offs);
		result_t r;
		r.mapped        = 1'b1;
		r.target_region = rg;
		r.bank_index    = BANK_W'(bank);
		r.region_offset = OFFS_W'(offs);
		r.writable      = (rg == REGION_RAM) || (rg == REGION_VIDEO);
		return r;
	endfunction

	function automatic result_t translate_address(latches_t l, cfg_t c, logic [ADDR_W-1:0] a);
		result_t     r;
		int unsigned ai;
		r  = '0;
		ai = a;
		case (c.model)
			MODEL_FIRST, MODEL_BASIC: begin
				if (l.port_a[PA_RAM0_BIT] && ai < 'h4000)
					r = region_hit(REGION_RAM, 0, ai);
				if (l.port_a[PA_VIDEO_BIT] && ai >= 'h8000 && ai < 'hC000)
					r = region_hit(REGION_VIDEO, 0, ai - 'h8000);
				if (c.model == MODEL_BASIC && l.port_a[PA_BASIC_BIT] &&
						ai >= 'hC000 && ai < 'hE000)
					r = region_hit(REGION_BASIC, 0, ai - 'hC000);
				if (l.port_a[PA_ROME_BIT] && ai >= 'hE000 && (ai - 'hE000) < c.rom_e_size)
					r = region_hit(REGION_ROME, 0, ai - 'hE000);
			end
			MODEL_EXT: begin
				if (l.port_a[PA_RAM0_BIT] && ai < 'h4000)
					r = region_hit(REGION_RAM, 0, ai);
				if (l.ram_rom_en[RE_RAM1_BIT] && ai >= 'h4000 && ai < 'h8000)
					r = region_hit(REGION_RAM, 1, ai - 'h4000);
				if (l.port_b[PB_RAM8_BIT] && ai >= 'h8000 && ai < 'hC000)
					r = region_hit(REGION_RAM, l.bank_sel[BS_RAM3_BIT] ? 3 : 2, ai - 'h8000);
				if (l.port_a[PA_VIDEO_BIT] && ai >= 'h8000 && ai < 'hC000) begin
					if (ai < 'hA800)
						r = region_hit(REGION_VIDEO, l.bank_sel[BS_VBANK_LSB +: 2],
								ai - 'h8000);
					else
						r = region_hit(REGION_VIDEO, 0, ai - 'h8000);
				end
				if (l.port_a[PA_BASIC_BIT] && ai >= 'hC000 && ai < 'hE000)
					r = region_hit(REGION_BASIC, 0, ai - 'hC000);
				if (l.ram_rom_en[RE_ROMC_BIT] && ai >= 'hC000 && (ai - 'hC000) < c.rom_c_size)
					r = region_hit(REGION_ROMC, 0, ai - 'hC000);
				if (l.port_a[PA_ROME_BIT] && ai >= 'hE000 && (ai - 'hE000) < c.rom_e_size)
					r = region_hit(REGION_ROME, 0, ai - 'hE000);
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic compare_field(string name, int unsigned want, logic [OFFS_W-1:0] got);
		if (got !== OFFS_W'(want))
			report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_copy = '0;
			cfg_copy.model      = MODEL_RESET;
			cfg_copy.rom_e_size = ROME_RESET;
			cfg_copy.rom_c_size = ROMC_RESET;
			expected_translations.delete();
			err_count   = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_MACHINE_MODEL: cfg_copy.model = model_t'(cfg_data[MODEL_W-1:0]);
					CFG_OS_ROM_E_SIZE: cfg_copy.rom_e_size = cfg_data[ROME_SIZE_W-1:0];
					CFG_OS_ROM_C_SIZE: cfg_copy.rom_c_size = cfg_data[ROMC_SIZE_W-1:0];
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (expected_translations.size() == 0) begin
					report_mismatch("result transfer with no item outstanding");
				end else begin
					oldest = expected_translations.pop_front();
					compare_field("mapped", oldest.mapped, mapped);
					compare_field("target_region", oldest.target_region, target_region);
					compare_field("bank_index", oldest.bank_index, bank_index);
					compare_field("region_offset", oldest.region_offset, region_offset);
					compare_field("writable", oldest.writable, writable);
				end
			end
			if (item_valid && !item_stall) begin
				if (func == FUNC_WRITE) begin
					case (latch_sel_t'(latch_select))
						SEL_PORT_A: latch_copy.port_a = latch_data;
						SEL_PORT_B: latch_copy.port_b = latch_data;
						SEL_BANK_SEL: begin
							if (cfg_copy.model == MODEL_EXT)
								latch_copy.bank_sel = latch_data;
						end
						SEL_RAM_ROM_EN: begin
							if (cfg_copy.model == MODEL_EXT)
								latch_copy.ram_rom_en = latch_data;
						end
						default: ;
					endcase
				end
				expected_translations.push_back(
						translate_address(latch_copy, cfg_copy, cpu_address));
			end
			mismatches  <= err_count;
			outstanding <= expected_translations.size();
		end
	end

endmodule

/* tb/sv/bank_switch_address_decoder_tb.sv */
// ----------------------------------------------------------------------------
// Bank-switch address decoder testbench
// Drives latch writes and address translations through several machine
// models and ROM sizes, with random idle cycles on both channels, a quiet
// stretch and one long receiver hold-off; a monitor checks every result.
// ----------------------------------------------------------------------------
module bank_switch_address_decoder_tb;
	import bsad_pkg::*;

	localparam logic FUNC_XLATE    = ~FUNC_WRITE;
	localparam int   ITEMS_PER_SET = 135;
	localparam int   SET_COUNT     = 10;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   item_valid;
	logic                   item_stall;
	logic                   func;
	logic [SEL_W-1:0]       latch_select;
	logic [LATCH_W-1:0]     latch_data;
	logic [ADDR_W-1:0]      cpu_address;
	logic                   result_valid;
	logic                   result_stall;
	logic                   mapped;
	logic [REGION_W-1:0]    target_region;
	logic [BANK_W-1:0]      bank_index;
	logic [OFFS_W-1:0]      region_offset;
	logic                   writable;
	int unsigned            mismatches;
	int unsigned            outstanding;

	bit          quiet;
	int unsigned hold_requests;
	int unsigned holds_done;
	cfg_t        cur_cfg;

	bank_switch_address_decoder u_top (.*);

	bsad_translation_monitor u_monitor (.*);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic send_item(input logic f, input latch_sel_t s, input logic [LATCH_W-1:0] d,
			input logic [ADDR_W-1:0] a);
		while (!quiet && $urandom_range(0, 99) < 7) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid   <= 1'b1;
		func         <= f;
		latch_select <= s;
		latch_data   <= d;
		cpu_address  <= a;
		do @(posedge clk); while (item_stall);
	endtask

	function automatic logic [ADDR_W-1:0] pick_address(cfg_t c);
		logic [ADDR_W-1:0] a;
		case ($urandom_range(0, 23))
			0: a = 16'h0000;
			1: a = 16'h3FFF;
			2: a = 16'h4000;
			3: a = 16'h7FFF;
			4: a = 16'h8000;
			5: a = 16'hA7FF;
			6: a = 16'hA800;
			7: a = 16'hBFFF;
			8: a = 16'hC000;
			9: a = 16'hDFFF;
			10: a = 16'hE000;
			11: a = 16'hFFFF;
			12: a = 16'hE000 + ADDR_W'(c.rom_e_size);
			13: a = 16'hE000 + ADDR_W'(c.rom_e_size) - 16'd1;
			14: a = 16'hC000 + ADDR_W'(c.rom_c_size);
			15: a = 16'hC000 + ADDR_W'(c.rom_c_size) - 16'd1;
			default: a = ADDR_W'($urandom);
		endcase
		if ($urandom_range(0, 3) == 0)
			a = a + ADDR_W'($urandom_range(0, 2)) - 16'd1;
		return a;
	endfunction

	task automatic send_random_item();
		send_item(($urandom_range(0, 99) < 35) ? FUNC_WRITE : FUNC_XLATE,
				latch_sel_t'($urandom_range(0, 3)), LATCH_W'($urandom),
				pick_address(cur_cfg));
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic set_config(cfg_t c);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MACHINE_MODEL;
		cfg_data  <= CFG_DATA_W'(c.model);
		@(posedge clk);
		cfg_index <= CFG_OS_ROM_E_SIZE;
		cfg_data  <= CFG_DATA_W'(c.rom_e_size);
		@(posedge clk);
		cfg_index <= CFG_OS_ROM_C_SIZE;
		cfg_data  <= CFG_DATA_W'(c.rom_c_size);
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_cfg = c;
	endtask

	// Receiver: random stall, none while quiet, and a long hold-off on request.
	initial begin
		result_stall <= 1'b0;
		holds_done = 0;
		forever begin
			if (hold_requests != holds_done) begin
				result_stall <= 1'b1;
				repeat (60) @(posedge clk);
				holds_done++;
			end else begin
				result_stall <= !quiet && ($urandom_range(0, 99) < 7);
				@(posedge clk);
			end
		end
	end

	initial begin
		#(12 * 400000);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		cfg_t c;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= CFG_MACHINE_MODEL;
		cfg_data     <= '0;
		item_valid   <= 1'b0;
		func         <= FUNC_XLATE;
		latch_select <= SEL_PORT_A;
		latch_data   <= '0;
		cpu_address  <= '0;
		quiet = 1'b0;
		hold_requests = 0;
		cur_cfg.model      = MODEL_RESET;
		cur_cfg.rom_e_size = ROME_RESET;
		cur_cfg.rom_c_size = ROMC_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration, latches all clear.
		send_item(FUNC_XLATE, SEL_PORT_A, 8'hFF, 16'h0000);
		send_item(FUNC_XLATE, SEL_PORT_A, 8'h00, 16'hFFFF);
		send_item(FUNC_WRITE, SEL_PORT_A, 8'h87, 16'h0000);
		send_item(FUNC_WRITE, SEL_PORT_B, 8'h20, 16'h8000);
		send_item(FUNC_WRITE, SEL_BANK_SEL, 8'h16, 16'hA7FF);
		send_item(FUNC_XLATE, SEL_PORT_A, 8'h00, 16'hA800);
		send_item(FUNC_WRITE, SEL_RAM_ROM_EN, 8'h81, 16'h4000);
		send_item(FUNC_XLATE, SEL_PORT_B, 8'h00, 16'h7FFF);
		send_item(FUNC_XLATE, SEL_PORT_B, 8'h00, 16'hC000);
		send_item(FUNC_XLATE, SEL_PORT_B, 8'h00, 16'hCFFF);
		send_item(FUNC_XLATE, SEL_PORT_B, 8'h00, 16'hD000);
		send_item(FUNC_XLATE, SEL_PORT_B, 8'h00, 16'hDFFF);
		send_item(FUNC_XLATE, SEL_PORT_B, 8'h00, 16'hE000);
		send_item(FUNC_XLATE, SEL_PORT_B, 8'h00, 16'hFFFF);
		send_item(FUNC_WRITE, SEL_PORT_A, 8'h00, 16'h9000);
		send_item(FUNC_WRITE, SEL_BANK_SEL, 8'h00, 16'hBFFF);
		send_item(FUNC_WRITE, SEL_PORT_A, 8'hFF, 16'h3FFF);
		send_item(FUNC_WRITE, SEL_PORT_B, 8'hFF, 16'hBFFF);
		send_item(FUNC_WRITE, SEL_BANK_SEL, 8'hFF, 16'h8000);
		send_item(FUNC_WRITE, SEL_RAM_ROM_EN, 8'hFF, 16'hC000);
		send_item(FUNC_WRITE, SEL_RAM_ROM_EN, 8'h00, 16'h4000);

		for (int set = 0; set < SET_COUNT; set++) begin
			case (set)
				1: c = '{MODEL_FIRST, 14'd8192, 13'd0};
				2: c = '{MODEL_BASIC, 14'd0, 13'd4096};
				3: c = '{MODEL_EXT, 14'd16383, 13'd8191};
				4: c = '{MODEL_EXT, 14'd1, 13'd1};
				5: c = '{MODEL_NONE, 14'd4096, 13'd2048};
				6: c = '{MODEL_BASIC, 14'($urandom_range(0, 16383)), 13'($urandom_range(0, 8191))};
				7: c = '{MODEL_EXT, 14'($urandom_range(0, 8192)), 13'($urandom_range(0, 4096))};
				8: c = '{MODEL_FIRST, 14'($urandom_range(0, 8192)), 13'($urandom_range(0, 4096))};
				default: c = '{MODEL_EXT, ROME_RESET, ROMC_RESET};
			endcase
			if (set != 0) begin
				wait_drained();
				set_config(c);
			end
			quiet = (set == 2);
			for (int n = 0; n < ITEMS_PER_SET; n++) begin
				if (set == 4 && n == 40)
					hold_requests++;
				send_random_item();
			end
		end
		quiet = 1'b0;

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
rtl/bsad_pkg.sv
rtl/bsad_ctrl_regs.sv
rtl/bsad_decode.sv
rtl/bank_switch_address_decoder.sv
tb/sv/bsad_translation_monitor.sv
tb/sv/bank_switch_address_decoder_tb.sv
